// ----- hdl/dpds_pkg.sv -----
// shared types and constants of the dual periodic deadline scheduler
`default_nettype none

package dpds_pkg;

    localparam int IV_BITS = 32;
    localparam int CFG_IDX_BITS = 2;
    localparam logic [IV_BITS-1:0] IV_RESET = 32'd1000;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_POLL  = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PING_INTERVAL    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NETWORK_INTERVAL = 2'd1;

    localparam logic TMR_PING = 1'b0;
    localparam logic TMR_NET  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_SUB,
        ST_ADD,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// ----- hdl/dpds_div.sv -----
// bit-serial restoring remainder unit
`default_nettype none

module dpds_div #(
    parameter int DW = 63,
    parameter int VW = 32
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic               done,
    output logic [VW-1:0]      remainder
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] num_reg, num_next;
    logic [VW-1:0] den_reg, den_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [VW:0]   shifted;
    logic [VW+1:0] trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    always_comb begin
        shifted   = {rem_reg, num_reg[DW-1]};
        trial     = {1'b0, shifted} - {2'b00, den_reg};
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[DW-2:0], 1'b0};
            if (!trial[VW+1]) begin
                rem_next = trial[VW-1:0];
            end else begin
                rem_next = shifted[VW-1:0];
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ----- hdl/dual_periodic_deadline_scheduler_core.sv -----
// top level of the dual periodic deadline scheduler
//
// two periodic deadlines, ping and network, share one sequencer and one
// bit-serial remainder unit. the input channel (s_) takes a command word:
// start arms both timers at s_now_ms plus their interval, poll reports which
// enabled timers have reached their deadline and moves each due deadline past
// now, skipping missed periods. every input word gives exactly one result
// word on the m_ channel with the due and active flags.
// the user must write intervals through the cfg_ port only while the block is
// idle; the block itself does not enforce this. a zero interval acts as one.
// a start checks each timer in turn, then goes to the output state; a poll
// checks each timer and, for each due timer, runs the remainder unit, then the
// subtract and add steps. a deadline past the time range disables its timer.
// one word is in work at a time; s_ready is high only when the sequencer is
// idle. the result sits in an output register, so a new word is taken while
// the receiver stalls; the next result then waits until the first is taken.
// synchronous reset disables both timers, restores the intervals to 1000 and
// drops any pending result.
`default_nettype none

module dual_periodic_deadline_scheduler_core #(
    parameter int TIME_BITS = 63
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_command,
    input  wire logic [TIME_BITS-1:0]              s_now_ms,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_ping_due,
    output logic                                   m_network_due,
    output logic                                   m_ping_active,
    output logic                                   m_network_active,
    input  wire logic                              cfg_wr_en,
    input  wire logic [dpds_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [dpds_pkg::IV_BITS-1:0]      cfg_wr_data
);

    localparam int IVB = dpds_pkg::IV_BITS;

    dpds_pkg::state_t state_reg, state_next;

    logic [IVB-1:0]       piv_reg, niv_reg;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic                 cmd_reg, cmd_next;
    logic                 sel_reg, sel_next;
    logic [TIME_BITS-1:0] dl_reg [2];
    logic [TIME_BITS-1:0] dl_next [2];
    logic [1:0]           en_reg, en_next;
    logic [1:0]           due_reg, due_next;
    logic [TIME_BITS-1:0] base_reg, base_next;
    logic                 m_valid_reg, m_valid_next;
    logic [3:0]           m_flags_reg, m_flags_next;

    logic [IVB-1:0]       iv_raw;
    logic [IVB-1:0]       iv_eff;
    logic [TIME_BITS:0]   arm_sum;
    logic [TIME_BITS:0]   adv_sum;
    logic [TIME_BITS-1:0] div_dividend;
    logic                 div_start;
    logic                 div_done;
    logic [IVB-1:0]       div_rem;

    dpds_div #(
        .DW (TIME_BITS),
        .VW (IVB)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (iv_eff),
        .done      (div_done),
        .remainder (div_rem)
    );

    // interval registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            piv_reg <= dpds_pkg::IV_RESET;
            niv_reg <= dpds_pkg::IV_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == dpds_pkg::CFG_PING_INTERVAL) begin
                piv_reg <= cfg_wr_data;
            end
            if (cfg_index == dpds_pkg::CFG_NETWORK_INTERVAL) begin
                niv_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dpds_pkg::ST_IDLE;
            en_reg      <= '0;
            sel_reg     <= dpds_pkg::TMR_PING;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            en_reg      <= en_next;
            sel_reg     <= sel_next;
            m_valid_reg <= m_valid_next;
        end
        now_reg     <= now_next;
        cmd_reg     <= cmd_next;
        dl_reg[0]   <= dl_next[0];
        dl_reg[1]   <= dl_next[1];
        due_reg     <= due_next;
        base_reg    <= base_next;
        m_flags_reg <= m_flags_next;
    end

    always_comb begin
        iv_raw       = (sel_reg == dpds_pkg::TMR_NET) ? niv_reg : piv_reg;
        iv_eff       = (iv_raw == '0) ? IVB'(1) : iv_raw;
        arm_sum      = {1'b0, now_reg} + (TIME_BITS + 1)'(iv_eff);
        adv_sum      = {1'b0, base_reg} + (TIME_BITS + 1)'(iv_eff);
        div_dividend = now_reg - dl_reg[sel_reg];
        div_start    = 1'b0;

        state_next   = state_reg;
        now_next     = now_reg;
        cmd_next     = cmd_reg;
        sel_next     = sel_reg;
        dl_next[0]   = dl_reg[0];
        dl_next[1]   = dl_reg[1];
        en_next      = en_reg;
        due_next     = due_reg;
        base_next    = base_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_flags_next = m_flags_reg;

        unique case (state_reg)
            dpds_pkg::ST_IDLE: begin
                if (s_valid) begin
                    now_next   = s_now_ms;
                    cmd_next   = s_command;
                    sel_next   = dpds_pkg::TMR_PING;
                    due_next   = '0;
                    state_next = dpds_pkg::ST_CHECK;
                end
            end
            dpds_pkg::ST_CHECK: begin
                if (cmd_reg == dpds_pkg::CMD_START) begin
                    if (arm_sum[TIME_BITS]) begin
                        en_next[sel_reg] = 1'b0;
                    end else begin
                        en_next[sel_reg] = 1'b1;
                        dl_next[sel_reg] = arm_sum[TIME_BITS-1:0];
                    end
                    if (sel_reg == dpds_pkg::TMR_NET) begin
                        state_next = dpds_pkg::ST_OUT;
                    end else begin
                        sel_next = dpds_pkg::TMR_NET;
                    end
                end else if (en_reg[sel_reg] && now_reg >= dl_reg[sel_reg]) begin
                    div_start  = 1'b1;
                    state_next = dpds_pkg::ST_DIV;
                end else if (sel_reg == dpds_pkg::TMR_NET) begin
                    state_next = dpds_pkg::ST_OUT;
                end else begin
                    sel_next = dpds_pkg::TMR_NET;
                end
            end
            dpds_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = dpds_pkg::ST_SUB;
                end
            end
            dpds_pkg::ST_SUB: begin
                // last deadline at or below now
                base_next  = now_reg - TIME_BITS'(div_rem);
                state_next = dpds_pkg::ST_ADD;
            end
            dpds_pkg::ST_ADD: begin
                due_next[sel_reg] = 1'b1;
                if (adv_sum[TIME_BITS]) begin
                    en_next[sel_reg] = 1'b0;
                end else begin
                    dl_next[sel_reg] = adv_sum[TIME_BITS-1:0];
                end
                if (sel_reg == dpds_pkg::TMR_NET) begin
                    state_next = dpds_pkg::ST_OUT;
                end else begin
                    sel_next   = dpds_pkg::TMR_NET;
                    state_next = dpds_pkg::ST_CHECK;
                end
            end
            dpds_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_flags_next = {en_reg[1], en_reg[0], due_reg[1], due_reg[0]};
                    state_next   = dpds_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dpds_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_ready          = (state_reg == dpds_pkg::ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_ping_due       = m_flags_reg[0];
    assign m_network_due    = m_flags_reg[1];
    assign m_ping_active    = m_flags_reg[2];
    assign m_network_active = m_flags_reg[3];

endmodule

`default_nettype wire

// ----- hdl/dpds_chk.sv -----
// port-level assertions for the dual periodic deadline scheduler
`default_nettype none

module dpds_chk #(
    parameter int TIME_BITS = 63
) (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_valid,
    input wire logic                              s_ready,
    input wire logic                              s_command,
    input wire logic [TIME_BITS-1:0]              s_now_ms,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic                              m_ping_due,
    input wire logic                              m_network_due,
    input wire logic                              m_ping_active,
    input wire logic                              m_network_active
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_ping_due) && $stable(m_network_due)
            && $stable(m_ping_active) && $stable(m_network_active))
        else $error("result word changed while stalled");

    // waiting input word holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_command) && $stable(s_now_ms))
        else $error("input word changed while waiting");

    // one word in work at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again right after an accept");

    // a result can only appear after an input word was in work
    a_result_needs_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result word without work");

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("result or busy state survived reset");

endmodule

bind dual_periodic_deadline_scheduler_core dpds_chk #(.TIME_BITS(TIME_BITS)) u_dpds_chk (.*);

`default_nettype wire

// ----- tb/tb_dual_periodic_deadline_scheduler_core.sv -----
// testbench for the dual periodic deadline scheduler core: timer shadow, stimulus and checks
`timescale 1ns / 100ps

module tb_dual_periodic_deadline_scheduler_core;
    import dpds_pkg::*;

    localparam logic [62:0] NOW_TOP  = {63{1'b1}};
    localparam logic [63:0] TIME_MAX = {1'b0, NOW_TOP};

    typedef struct packed {
        logic ping_due;
        logic network_due;
        logic ping_active;
        logic network_active;
    } flags_t;

    class deadline_shadow;
        logic [IV_BITS-1:0] ping_iv = IV_RESET;
        logic [IV_BITS-1:0] net_iv  = IV_RESET;
        logic [62:0]        ping_dl = '0;
        logic [62:0]        net_dl  = '0;
        bit                 ping_en = 1'b0;
        bit                 net_en  = 1'b0;
        flags_t             pending_flags[$];
        int                 errors  = 0;
        int                 checked = 0;
        int                 starts  = 0;
        int                 polls   = 0;
        int                 dues    = 0;
        int                 lapses  = 0;

        function void set_interval(logic [CFG_IDX_BITS-1:0] idx, logic [IV_BITS-1:0] value);
            case (idx)
                CFG_PING_INTERVAL:    ping_iv = value;
                CFG_NETWORK_INTERVAL: net_iv  = value;
                default: ;
            endcase
        endfunction

        function bit arm_timer(input logic [63:0] now, input logic [63:0] iv,
                               inout logic [62:0] dl);
            if (now > TIME_MAX - iv)
                return 1'b0;
            dl = now + iv;
            return 1'b1;
        endfunction

        function bit advance_timer(input logic [63:0] now, input logic [63:0] iv,
                                   inout logic [62:0] dl, inout bit en);
            logic [63:0] count;
            logic [63:0] room;
            if (!en || now < {1'b0, dl})
                return 1'b0;
            count = (now - {1'b0, dl}) / iv + 64'd1;
            room  = TIME_MAX - {1'b0, dl};
            if (count > room / iv) begin
                en = 1'b0;
                lapses++;
            end else begin
                dl = {1'b0, dl} + count * iv;
            end
            return 1'b1;
        endfunction

        function void take_word(logic cmd, logic [62:0] now);
            flags_t      f;
            logic [63:0] t;
            logic [63:0] piv;
            logic [63:0] niv;
            t   = {1'b0, now};
            piv = (ping_iv == '0) ? 64'd1 : {32'd0, ping_iv};
            niv = (net_iv == '0) ? 64'd1 : {32'd0, net_iv};
            f   = '0;
            if (cmd == CMD_START) begin
                starts++;
                ping_en = arm_timer(t, piv, ping_dl);
                net_en  = arm_timer(t, niv, net_dl);
            end else begin
                polls++;
                f.ping_due    = advance_timer(t, piv, ping_dl, ping_en);
                f.network_due = advance_timer(t, niv, net_dl, net_en);
            end
            f.ping_active    = ping_en;
            f.network_active = net_en;
            dues += int'(f.ping_due) + int'(f.network_due);
            pending_flags.push_back(f);
        endfunction

        function void compare_flag(string field, logic want, logic got);
            if (want !== got) begin
                errors++;
                if (errors <= 100)
                    $display("%0t mismatch on %s: expected %b, actual %b",
                             $time, field, want, got);
            end
        endfunction

        function void check_word(flags_t got);
            flags_t want;
            if (pending_flags.size() == 0) begin
                errors++;
                if (errors <= 100)
                    $display("%0t result word with nothing expected: actual %b", $time, got);
                return;
            end
            want = pending_flags.pop_front();
            checked++;
            compare_flag("ping_due", want.ping_due, got.ping_due);
            compare_flag("network_due", want.network_due, got.network_due);
            compare_flag("ping_active", want.ping_active, got.ping_active);
            compare_flag("network_active", want.network_active, got.network_active);
        endfunction

        function int waiting();
            return pending_flags.size();
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_command;
    logic [62:0]             s_now_ms;
    logic                    m_valid;
    logic                    m_ready;
    logic                    m_ping_due;
    logic                    m_network_due;
    logic                    m_ping_active;
    logic                    m_network_active;
    logic                    cfg_wr_en;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [IV_BITS-1:0]      cfg_wr_data;

    deadline_shadow timers;
    logic [63:0]    clock_ms;
    int             burst_left;
    int             settings_used;
    bit             hold_req;

    dual_periodic_deadline_scheduler_core #(.TIME_BITS(63)) DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_now_ms         (s_now_ms),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_ping_due       (m_ping_due),
        .m_network_due    (m_network_due),
        .m_ping_active    (m_ping_active),
        .m_network_active (m_network_active),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            timers.check_word({m_ping_due, m_network_due, m_ping_active, m_network_active});
    end

    initial begin
        int unsigned run;
        int unsigned mode;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (600) @(posedge aclk);
            end else begin
                mode = $urandom_range(0, 3);
                run  = $urandom_range(5, 60);
                repeat (run) begin
                    case (mode)
                        0: m_ready <= 1'b1;
                        1: m_ready <= ($urandom_range(0, 3) != 0);
                        2: m_ready <= 1'($urandom_range(0, 1));
                        default: m_ready <= ($urandom_range(0, 7) == 0);
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        return (a + b > TIME_MAX) ? TIME_MAX : a + b;
    endfunction

    function automatic logic [IV_BITS-1:0] pick_interval();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(2, 64);
            4: return $urandom_range(65, 100000);
            default: return $urandom;
        endcase
    endfunction

    task automatic offer(input logic cmd, input logic [62:0] now);
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_now_ms  <= now;
        do @(posedge aclk); while (!s_ready);
        timers.take_word(cmd, now);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 200)
                                                 : $urandom_range(1, 12))
                @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 15);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (timers.waiting() != 0)
            @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic configure(input logic [IV_BITS-1:0] ping_iv, input logic [IV_BITS-1:0] net_iv);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_PING_INTERVAL;
        cfg_wr_data <= ping_iv;
        @(posedge aclk);
        cfg_index   <= CFG_NETWORK_INTERVAL;
        cfg_wr_data <= net_iv;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        timers.set_interval(CFG_PING_INTERVAL, ping_iv);
        timers.set_interval(CFG_NETWORK_INTERVAL, net_iv);
        settings_used++;
    endtask

    task automatic random_word();
        logic [63:0] iv;
        logic [63:0] target;
        logic [62:0] now;
        logic        cmd;
        int unsigned r;
        r   = $urandom_range(0, 99);
        cmd = CMD_POLL;
        iv  = $urandom_range(0, 1) ? {32'd0, timers.ping_iv} : {32'd0, timers.net_iv};
        if (iv == 64'd0)
            iv = 64'd1;
        if (r < 8) begin
            cmd = CMD_START;
        end else if (r < 30) begin
            target = $urandom_range(0, 1) ? {1'b0, timers.ping_dl} : {1'b0, timers.net_dl};
            if (target > clock_ms)
                clock_ms = sat_add(target - 64'd1, $urandom_range(0, 2));
        end else if (r < 55) begin
            clock_ms = sat_add(clock_ms, $urandom_range(0, 3));
        end else if (r < 70) begin
            clock_ms = sat_add(clock_ms, iv * $urandom_range(1, 6) + $urandom_range(0, 2));
        end else if (r < 76) begin
            clock_ms = sat_add(clock_ms, {1'b0, 63'({$urandom, $urandom})} >> $urandom_range(0, 62));
        end else if (r < 84) begin
            clock_ms = TIME_MAX - iv * $urandom_range(0, 3) - $urandom_range(0, 2);
            cmd = CMD_START;
        end else if (r < 92) begin
            clock_ms = {1'b0, 63'({$urandom, $urandom})} >> $urandom_range(20, 62);
            cmd = CMD_START;
        end
        now = clock_ms[62:0];
        if (r >= 92) begin
            now = 63'({$urandom, $urandom});
            cmd = 1'($urandom_range(0, 1));
        end
        offer(cmd, now);
    endtask

    initial begin
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_command   <= CMD_START;
        s_now_ms    <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= CFG_PING_INTERVAL;
        cfg_wr_data <= '0;
        timers        = new();
        clock_ms      = '0;
        burst_left    = 0;
        settings_used = 1;
        hold_req      = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        offer(CMD_POLL, 63'd0);
        offer(CMD_START, 63'd0);
        offer(CMD_POLL, 63'd999);
        offer(CMD_POLL, 63'd1000);
        offer(CMD_POLL, 63'd5500);
        offer(CMD_POLL, 63'd6499);
        offer(CMD_START, NOW_TOP);
        offer(CMD_POLL, NOW_TOP);
        offer(CMD_START, NOW_TOP - 63'd1000);
        offer(CMD_POLL, NOW_TOP);
        offer(CMD_START, NOW_TOP - 63'd999);
        offer(CMD_START, NOW_TOP - 63'd2500);
        offer(CMD_POLL, NOW_TOP - 63'd1500);
        offer(CMD_POLL, NOW_TOP);
        wait_idle();
        configure(32'd0, 32'hFFFF_FFFF);
        offer(CMD_START, 63'd10);
        offer(CMD_POLL, 63'd11);
        offer(CMD_POLL, 63'd5);
        offer(CMD_POLL, 63'd10 + 63'h0_FFFF_FFFF);
        offer(CMD_START, NOW_TOP - 63'h0_FFFF_FFFF);
        offer(CMD_POLL, NOW_TOP);

        for (int p = 0; p < 6; p++) begin
            wait_idle();
            case (p)
                0: configure(32'd0, 32'hFFFF_FFFF);
                1: configure(32'hFFFF_FFFF, 32'd1);
                2: configure($urandom_range(1, 64), $urandom_range(1, 64));
                3: configure($urandom, $urandom_range(1, 65535));
                4: configure(32'd1, 32'd0);
                default: configure(pick_interval(), pick_interval());
            endcase
            clock_ms = '0;
            if (p == 1)
                hold_req = 1'b1;
            repeat (225) random_word();
        end
        wait_idle();

        $display("run covered %0d start and %0d poll words under %0d interval settings",
                 timers.starts, timers.polls, settings_used);
        $display("%0d words checked, %0d due flags, %0d timers lapsed at the top of the range",
                 timers.checked, timers.dues, timers.lapses);
        if (timers.errors == 0 && timers.waiting() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
